[rtl/crc16rs_pkg.sv]
// Shared types and the byte update function of the reflected CRC-16 stream block.
`default_nettype none

package crc16rs_pkg;

  localparam int unsigned CrcWidth  = 16;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0] PolyReset = 16'hA001;
  localparam logic [CrcWidth-1:0] InitReset = 16'hFFFF;

  // Configuration register indexes.
  localparam logic CfgPolynomial   = 1'b0;
  localparam logic CfgInitialValue = 1'b1;

  typedef struct packed {
    logic [CrcWidth-1:0]  crc;
    logic [ByteWidth-1:0] hold0;
    logic [ByteWidth-1:0] hold1;
    logic [1:0]           count;
    logic                 mode;
  } state_t;

  typedef struct packed {
    logic [CrcWidth-1:0] crc_swapped;
    logic                match;
    logic                too_short;
  } result_t;

  // Eight unrolled shift and conditional XOR steps.
  function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0]  crc,
                                                   input logic [ByteWidth-1:0] data,
                                                   input logic [CrcWidth-1:0]  poly);
    logic [CrcWidth-1:0] t;
    t = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int k = 0; k < ByteWidth; k++) begin
      if (t[0]) begin
        t = (t >> 1) ^ poly;
      end else begin
        t = t >> 1;
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/crc16rs_step.sv]
// Next-state and result logic for one message byte.
`default_nettype none

module crc16rs_step import crc16rs_pkg::*; (
  input  state_t               state_i,
  input  logic [CrcWidth-1:0]  poly_i,
  input  logic [CrcWidth-1:0]  init_i,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 first_i,
  input  logic                 mode_i,
  output state_t               state_o,
  output result_t              result_o
);

  state_t              base;
  state_t              nxt;
  logic [CrcWidth-1:0] swapped;

  always_comb begin
    base = state_i;
    if (first_i) begin
      base.crc   = init_i;
      base.hold0 = '0;
      base.hold1 = '0;
      base.count = 2'd0;
      base.mode  = mode_i;
    end

    nxt = base;
    if (!base.mode) begin
      nxt.crc = crc_byte(base.crc, data_byte_i, poly_i);
    end else if (base.count[1]) begin
      // Two bytes already held: the oldest one is now known to be message data.
      nxt.crc   = crc_byte(base.crc, base.hold0, poly_i);
      nxt.hold0 = base.hold1;
      nxt.hold1 = data_byte_i;
    end else if (!base.count[0]) begin
      nxt.hold0 = data_byte_i;
      nxt.count = 2'd1;
    end else begin
      nxt.hold1 = data_byte_i;
      nxt.count = 2'd2;
    end
  end

  assign swapped = {nxt.crc[ByteWidth-1:0], nxt.crc[CrcWidth-1:ByteWidth]};

  assign state_o              = nxt;
  assign result_o.crc_swapped = swapped;
  assign result_o.too_short   = nxt.mode & ~nxt.count[1];
  assign result_o.match       = nxt.mode & nxt.count[1] & ({nxt.hold0, nxt.hold1} == swapped);

endmodule

`default_nettype wire

[rtl/crc16rs_obuf.sv]
// Two-entry result buffer: an output register with a skid slot behind it.
`default_nettype none

module crc16rs_obuf import crc16rs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      if (push_i) begin
        out_valid_d = 1'b1;
        out_d       = result_i;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = result_i;
      end else begin
        out_valid_d = push_i;
        out_d       = result_i;
      end
    end else if (push_i) begin
      // The head is stalled, so the new result waits in the skid slot.
      skid_valid_d = 1'b1;
      skid_d       = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

[rtl/crc16_reflected_stream.sv]
// Top level of the streaming reflected CRC-16 block with compute and verify modes.
//
// The block takes one message byte per clock cycle while not stalled, with no
// gaps required: the CRC update of a byte is eight unrolled shift and XOR
// steps, combinational in front of the running state register, and the result
// of the byte marked last is registered into the output buffer. Results leave
// through an output register backed by a skid slot, so input transfers continue
// while a result waits; the input stalls only when both slots hold results.
// Configuration writes are always ready and take effect on the next byte.
`default_nettype none

module crc16_reflected_stream import crc16rs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [CrcWidth-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 first_i,
  input  logic                 last_i,
  input  logic                 mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CrcWidth-1:0]  crc_swapped_o,
  output logic                 match_o,
  output logic                 too_short_o
);

  logic [CrcWidth-1:0] poly_q, init_q;
  state_t              state_q, state_d;
  result_t             step_result;
  result_t             out_result;
  logic                in_xfer;
  logic                buf_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_xfer     = in_valid_i & ~buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
      init_q <= InitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPolynomial:   poly_q <= cfg_data_i;
        CfgInitialValue: init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crc16rs_step u_step (
    .state_i     (state_q),
    .poly_i      (poly_q),
    .init_i      (init_q),
    .data_byte_i (data_byte_i),
    .first_i     (first_i),
    .mode_i      (mode_i),
    .state_o     (state_d),
    .result_o    (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  crc16rs_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer & last_i),
    .result_i    (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign crc_swapped_o = out_result.crc_swapped;
  assign match_o       = out_result.match;
  assign too_short_o   = out_result.too_short;

endmodule

`default_nettype wire
